[rtl/foc_pkg.sv]
// foc_pkg: shared types and constants of the feedback opto compressor
// used by foc_div and feedback_opto_compressor; no dependencies
package foc_pkg;

  localparam int ENV_W = 28;               // envelope width, Q4.24
  localparam int ENV_FRAC = 24;
  localparam int GAIN_W = 17;              // linear gain, Q1.16
  localparam int DB_W = 15;                // reduction in dB, signed Q7.8
  localparam int LOG_STEPS = 16;           // squaring steps of the log2 fraction

  localparam int DIV_NUM_W = 41;
  localparam int DIV_DEN_W = 31;
  localparam int DIV_QUO_W = 17;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'd65536;
  localparam logic [GAIN_W-1:0] MIN_GAIN = 17'd655;
  localparam logic [18:0] DB_PER_OCTAVE = 19'd394566;  // 20*log10(2), Q16
  localparam logic [DB_W-1:0] DB_FLOOR = 15'd10240;
  localparam logic signed [DB_W-1:0] DB_MIN = -15'sd10240;

  localparam logic [23:0] FAST_COEFF_24 = 24'd16739216;
  localparam logic [23:0] SLOW_COEFF_24 = 24'd16770877;

  typedef enum logic [1:0] {
    CFG_AMOUNT     = 2'd0,
    CFG_FAST_COEFF = 2'd1,
    CFG_SLOW_COEFF = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GAIN,
    S_RND,
    S_DRV,
    S_DRV_W,
    S_SM0,
    S_SM1,
    S_SM2,
    S_DIV_GO,
    S_DIV_WAIT,
    S_NORM,
    S_LOG_ISSUE,
    S_LOG,
    S_DB,
    S_DB_W,
    S_OUT
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

endpackage

[rtl/feedback_opto_compressor.sv]
// feedback_opto_compressor: top level, sequencer around a shared multiplier
// depends on foc_pkg, foc_mul and foc_div
//
// Usage:
//   Input channel: sample_in with in_valid / in_stall. A request is taken
//   when in_valid is high and in_stall is low; in_stall stays high while a
//   sample is being worked on, so one sample is in flight at a time.
//   Output channel: sample_out and reduction_db with out_valid / out_stall,
//   held in an output register; a finished result waits there while the
//   next sample is already taken.
//   Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data;
//   index 0 amount (clamped to 1.0), 1 fast pole, 2 slow pole, 3 ignored.
//   cfg_ready is high while no sample is being worked on.
//   A new sample can be taken the cycle after the result enters the output
//   register. The sequencer waits on the 17-step divider and runs the 16
//   squarings of the log2 fraction on the shared multiplier.
//   Reset: envelopes clear, gain is unity, registers take their defaults.
//   A stalled output holds its data and the sequencer waits before loading.
module feedback_opto_compressor
  import foc_pkg::*;
#(
  parameter int SAMPLE_BITS = 24,
  parameter int COEFF_BITS = 24
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  output logic                                        in_stall,
  input  logic signed [SAMPLE_BITS-1:0]               sample_in,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output logic signed [SAMPLE_BITS-1:0]               sample_out,
  output logic signed [DB_W-1:0]                      reduction_db,
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [1:0]                                  cfg_index,
  input  logic [((COEFF_BITS > GAIN_W) ? COEFF_BITS : GAIN_W)-1:0] cfg_data
);

  localparam int SB = SAMPLE_BITS;
  localparam int CB = COEFF_BITS;
  localparam int MAX_SC = (SB > CB) ? SB : CB;
  localparam int MUL_W = (MAX_SC > 31) ? MAX_SC : 31;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W = CB + 30;
  localparam int DSHIFT = SB - 12;
  localparam int UP = (CB >= 24) ? CB - 24 : 0;
  localparam int DOWN = (CB >= 24) ? 0 : 24 - CB;
  localparam logic [CB-1:0] FAST_RST = CB'((64'(FAST_COEFF_24) << UP) >> DOWN);
  localparam logic [CB-1:0] SLOW_RST = CB'((64'(SLOW_COEFF_24) << UP) >> DOWN);

  state_t state, state_next;

  logic [GAIN_W-1:0] amount;
  logic [CB-1:0]     fast_coeff;
  logic [CB-1:0]     slow_coeff;
  logic [ENV_W-1:0]  fast_env;
  logic [ENV_W-1:0]  slow_env;
  logic [GAIN_W-1:0] gain;

  logic              neg;
  logic [SB-1:0]     mag;
  logic [SB-1:0]     outmag;
  logic [ENV_W-1:0]  drive;
  logic [ACC_W-1:0]  acc;
  logic              pass;
  logic [30:0]       m;
  logic [15:0]       frac;
  logic [3:0]        step;
  logic [4:0]        exp_p;
  logic [DB_W-1:0]   db_hold;

  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;
  div_req_t          div_req;
  logic              div_done;
  logic [DIV_QUO_W-1:0] quo;

  logic [ENV_W-1:0]  x_sel, prev_sel;
  logic [CB-1:0]     c_sel;
  logic [ACC_W-1:0]  sm_diff;
  logic [ENV_W-1:0]  sm_res;
  logic [DIV_DEN_W-1:0] denom;
  logic [31:0]       sq;
  logic [30:0]       m_new;
  logic [20:0]       lmag;
  logic [PROD_W-1:0] rnd_sum, drv_sum, db_sum;
  logic [DB_W-1:0]   db_mag;
  logic [GAIN_W-1:0] g_clamp;
  logic [4:0]        lead;
  logic [GAIN_W-1:0] amount_wr;
  logic              cfg_we;

  function automatic logic [4:0] lead_one(input logic [GAIN_W-1:0] g);
    logic [4:0] r;
    r = '0;
    for (int i = 0; i < GAIN_W; i++) begin
      if (g[i]) r = 5'(i);
    end
    return r;
  endfunction

  foc_mul #(.W(MUL_W)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  foc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quo  (quo)
  );

  assign in_stall = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign cfg_we = cfg_valid && cfg_ready;
  assign amount_wr = (cfg_data[GAIN_W-1:0] > UNITY_GAIN) ? UNITY_GAIN : cfg_data[GAIN_W-1:0];

  // smoother operands: first pass fast from drive, second pass slow from fast
  assign x_sel = pass ? fast_env : drive;
  assign prev_sel = pass ? slow_env : fast_env;
  assign c_sel = pass ? slow_coeff : fast_coeff;
  assign sm_diff = acc - prod[ACC_W-1:0];
  assign sm_res = sm_diff[CB +: ENV_W];

  assign denom = DIV_DEN_W'(1 << ENV_FRAC) + DIV_DEN_W'({slow_env, 2'b00})
               + DIV_DEN_W'(slow_env);
  assign rnd_sum = prod + PROD_W'(32768);
  assign drv_sum = prod + (PROD_W'(1) << (DSHIFT - 1));
  assign db_sum = prod + (PROD_W'(1) << 23);
  assign db_mag = (db_sum[PROD_W-1:24] > (PROD_W-24)'(DB_FLOOR))
                ? DB_FLOOR : db_sum[24 +: DB_W];
  assign g_clamp = (quo < MIN_GAIN) ? MIN_GAIN : ((quo > UNITY_GAIN) ? UNITY_GAIN : quo);
  assign lead = lead_one(gain);

  // one squaring per cycle; an overflow past 2.0 gives a fraction bit
  assign sq = prod[61:30];
  assign m_new = sq[31] ? sq[31:1] : sq[30:0];
  assign lmag = (21'(5'd16 - exp_p) << 16) - 21'(frac);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_a = '0;
    mul_b = '0;
    div_req.start = 1'b0;
    div_req.num = (DIV_NUM_W'(1) << 40) + DIV_NUM_W'(denom >> 1);
    div_req.den = denom;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_GAIN;
      end
      S_GAIN: begin
        mul_a = MUL_W'(mag);
        mul_b = MUL_W'(gain);
        state_next = S_RND;
      end
      S_RND: state_next = S_DRV;
      S_DRV: begin
        mul_a = MUL_W'(outmag);
        mul_b = MUL_W'(amount);
        state_next = S_DRV_W;
      end
      S_DRV_W: state_next = S_SM0;
      S_SM0: begin
        mul_a = MUL_W'(c_sel);
        mul_b = MUL_W'(prev_sel);
        state_next = S_SM1;
      end
      S_SM1: begin
        mul_a = MUL_W'(c_sel);
        mul_b = MUL_W'(x_sel);
        state_next = S_SM2;
      end
      S_SM2: state_next = pass ? S_DIV_GO : S_SM0;
      S_DIV_GO: begin
        div_req.start = 1'b1;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) state_next = S_NORM;
      end
      S_NORM: state_next = S_LOG_ISSUE;
      S_LOG_ISSUE: begin
        mul_a = MUL_W'(m);
        mul_b = MUL_W'(m);
        state_next = S_LOG;
      end
      S_LOG: begin
        mul_a = MUL_W'(m_new);
        mul_b = MUL_W'(m_new);
        if (step == 4'(LOG_STEPS - 1)) state_next = S_DB;
      end
      S_DB: begin
        mul_a = MUL_W'(lmag);
        mul_b = MUL_W'(DB_PER_OCTAVE);
        state_next = S_DB_W;
      end
      S_DB_W: state_next = S_OUT;
      S_OUT: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state, configuration and the compressor state
  always_ff @(posedge clk) begin
    if (rst) begin
      amount <= '0;
      fast_coeff <= FAST_RST;
      slow_coeff <= SLOW_RST;
      fast_env <= '0;
      slow_env <= '0;
      gain <= UNITY_GAIN;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_AMOUNT:     amount <= amount_wr;
          CFG_FAST_COEFF: fast_coeff <= cfg_data[CB-1:0];
          CFG_SLOW_COEFF: slow_coeff <= cfg_data[CB-1:0];
          default: ;
        endcase
      end
      if (state == S_SM2) begin
        if (pass) slow_env <= sm_res;
        else fast_env <= sm_res;
      end
      if (state == S_DIV_WAIT && div_done) gain <= g_clamp;
      if (state == S_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        neg <= sample_in[SB-1];
        mag <= sample_in[SB-1] ? SB'(-sample_in) : SB'(sample_in);
      end
      S_RND: outmag <= rnd_sum[16 +: SB];
      S_DRV_W: begin
        drive <= drv_sum[DSHIFT +: ENV_W];
        pass <= 1'b0;
      end
      S_SM0: acc <= (ACC_W'(x_sel) << CB) + (ACC_W'(1) << (CB - 1));
      S_SM1: acc <= acc + prod[ACC_W-1:0];
      S_SM2: pass <= 1'b1;
      S_NORM: begin
        exp_p <= lead;
        m <= 31'(gain) << (5'd30 - lead);
      end
      S_LOG_ISSUE: step <= '0;
      S_LOG: begin
        m <= m_new;
        frac <= {frac[14:0], sq[31]};
        step <= step + 1'b1;
      end
      S_DB_W: db_hold <= DB_W'(-db_mag);
      S_OUT: begin
        if (!out_valid || !out_stall) begin
          sample_out <= neg ? SB'(-outmag) : outmag;
          reduction_db <= db_hold;
        end
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    gain >= MIN_GAIN && gain <= UNITY_GAIN)
    else $error("gain left its clamp range");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (reduction_db <= 0 && reduction_db >= DB_MIN))
    else $error("reduction outside its range");

  assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV_WAIT)
    else $error("divider finished outside its wait state");

  assert property (@(posedge clk) disable iff (rst)
    amount <= UNITY_GAIN)
    else $error("amount above unity");

endmodule

[rtl/foc_mul.sv]
// foc_mul: shared unsigned multiplier with a registered product
// no package dependencies
module foc_mul #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [2*W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= (2*W)'(a) * (2*W)'(b);
  end

endmodule

[rtl/foc_div.sv]
// foc_div: restoring divider, one quotient bit per cycle
// depends on foc_pkg for the request struct and widths
module foc_div
  import foc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  div_req_t             req,
  output logic                 done,
  output logic [DIV_QUO_W-1:0] quo
);

  localparam int CNT_W = $clog2(DIV_QUO_W + 1);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_QUO_W-1:0] low_bits;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  // quotient fits in DIV_QUO_W bits, so the top numerator bits start below den
  assign trial = {rem, low_bits[DIV_QUO_W-1]};
  assign fits = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(DIV_QUO_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= DIV_DEN_W'(req.num[DIV_NUM_W-1:DIV_QUO_W]);
      low_bits <= req.num[DIV_QUO_W-1:0];
      den <= req.den;
    end else if (busy) begin
      rem <= fits ? DIV_DEN_W'(trial - {1'b0, den}) : trial[DIV_DEN_W-1:0];
      low_bits <= {low_bits[DIV_QUO_W-2:0], 1'b0};
      quo <= {quo[DIV_QUO_W-2:0], fits};
    end
  end

endmodule

[sim/tb_top.sv]
// tb_top: self-checking bench for feedback_opto_compressor, directed table then random phases
// depends on foc_pkg and rtl/feedback_opto_compressor.sv; a local predictor checks every result not typed in the table
module tb_top
  import foc_pkg::*;
;

  localparam int SMP_W = 24;
  localparam int CFG_W = (24 > GAIN_W) ? 24 : GAIN_W;
  localparam int N_PHASE = 10;
  localparam int PHASE_LEN = 195;
  localparam int WATCH_LIMIT = 3000;
  localparam int N_ROWS = 26;

  typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] smp;
    logic signed [DB_W-1:0]  db;
  } result_t;

  typedef struct packed {
    row_kind_t         kind;
    cfg_idx_t          idx;
    logic [CFG_W-1:0]  data;
    logic              typed;
    logic [SMP_W-1:0]  exp_smp;
    logic [DB_W-1:0]   exp_db;
  } dir_row_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SMP_W-1:0] sample_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SMP_W-1:0] sample_out;
  logic signed [DB_W-1:0] reduction_db;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // predictor state
  logic [ENV_W-1:0]  env_fast;
  logic [ENV_W-1:0]  env_slow;
  logic [GAIN_W-1:0] gain_q16;
  logic [GAIN_W-1:0] drive_amt;
  logic [23:0]       pole_fast;
  logic [23:0]       pole_slow;

  result_t pending_out[$];
  dir_row_t dir_tab [0:N_ROWS-1];
  bit in_up = 1'b0;
  bit calm = 1'b0;
  int err_cnt = 0;
  int n_checked = 0;
  int n_writes = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  int run_left = 0;

  feedback_opto_compressor #(.SAMPLE_BITS(SMP_W), .COEFF_BITS(24)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .sample_in(sample_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .sample_out(sample_out), .reduction_db(reduction_db),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [ENV_W-1:0] one_pole(input logic [23:0] c,
                                                input logic [ENV_W-1:0] prev,
                                                input logic [ENV_W-1:0] x);
    logic [63:0] acc;
    acc = 64'(c) * 64'(prev) + (64'd16777216 - 64'(c)) * 64'(x) + 64'd8388608;
    return acc[ENV_FRAC+ENV_W-1:ENV_FRAC];
  endfunction

  // log2 by normalization and repeated squaring, scaled to dB in signed Q7.8
  function automatic logic signed [DB_W-1:0] gain_db(input logic [63:0] g);
    int unsigned p;
    logic [63:0] m;
    logic [63:0] frac;
    logic [63:0] lmag;
    logic [63:0] mag;
    longint l;
    p = 0;
    frac = 0;
    while (p < 16 && (g >> (p + 1)) != 0) p++;
    m = g << (30 - p);
    for (int i = 0; i < LOG_STEPS; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    l = (longint'(p) - 16) * 65536 + longint'(frac);
    if (l >= 0) return '0;
    lmag = 64'(-l);
    mag = (lmag * 64'(DB_PER_OCTAVE) + (64'd1 << 23)) >> 24;
    if (mag > 64'(DB_FLOOR)) mag = 64'(DB_FLOOR);
    return DB_W'(64'd0 - mag);
  endfunction

  // apply gain, then update both envelopes and the gain for the next sample
  function automatic result_t compress_sample(input logic signed [SMP_W-1:0] s);
    logic [SMP_W-1:0] t;
    logic [63:0] mag;
    logic [63:0] outmag;
    logic [63:0] drv;
    logic [63:0] den;
    logic [63:0] g;
    result_t r;
    t = SMP_W'(0) - s;
    mag = s[SMP_W-1] ? 64'(t) : 64'(s[SMP_W-1:0]);
    outmag = (mag * 64'(gain_q16) + 64'd32768) >> 16;
    r.smp = s[SMP_W-1] ? SMP_W'(64'd0 - outmag) : outmag[SMP_W-1:0];
    drv = (outmag * 64'(drive_amt) + 64'd2048) >> 12;
    env_fast = one_pole(pole_fast, env_fast, drv[ENV_W-1:0]);
    env_slow = one_pole(pole_slow, env_slow, env_fast);
    den = (64'd1 << ENV_FRAC) + 64'd5 * 64'(env_slow);
    g = ((64'd1 << 40) + (den >> 1)) / den;
    if (g < 64'(MIN_GAIN)) g = 64'(MIN_GAIN);
    if (g > 64'(UNITY_GAIN)) g = 64'(UNITY_GAIN);
    gain_q16 = g[GAIN_W-1:0];
    r.db = gain_db(g);
    return r;
  endfunction

  task automatic lower_in();
    if (in_up) begin
      in_valid <= 1'b0;
      in_up = 1'b0;
    end
  endtask

  task automatic idle_in(input int n);
    lower_in();
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_out();
    lower_in();
    while (pending_out.size() != 0) @(posedge clk);
  endtask

  task automatic push_sample(input logic signed [SMP_W-1:0] v, input logic typed,
                             input result_t typed_res);
    result_t pr;
    sample_in <= v;
    if (!in_up) begin
      in_valid <= 1'b1;
      in_up = 1'b1;
    end
    do @(posedge clk); while (in_stall);
    pr = compress_sample(v);
    pending_out.push_back(typed ? typed_res : pr);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
    logic [GAIN_W-1:0] a;
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_AMOUNT: begin
        a = data[GAIN_W-1:0];
        drive_amt = (a > UNITY_GAIN) ? UNITY_GAIN : a;
        n_writes++;
      end
      CFG_FAST_COEFF: begin
        pole_fast = data[23:0];
        n_writes++;
      end
      CFG_SLOW_COEFF: begin
        pole_slow = data[23:0];
        n_writes++;
      end
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_pole();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 24'hFFFFFF;
      2: return 24'(FAST_COEFF_24);
      3: return CFG_W'($urandom);
      default: return 24'hFFFFFF - 24'($urandom_range(0, 200000));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_amount();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return CFG_W'(UNITY_GAIN);
      2: return CFG_W'($urandom);
      3: return CFG_W'($urandom_range(0, 65536));
      default: return 24'hFFFFFF;
    endcase
  endfunction

  function automatic logic signed [SMP_W-1:0] pick_sample(input int sh);
    logic signed [SMP_W-1:0] r;
    r = SMP_W'($urandom);
    case ($urandom_range(0, 15))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return SMP_W'($urandom_range(0, 3)) - 24'sd1;
      default: return r >>> sh;
    endcase
  endfunction

  // result checker, output stall bursts and watchdog
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("tb_top: watchdog expired with %0d results pending", pending_out.size());
        $display("tb_top: FAIL");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (pending_out.size() == 0) begin
          $error("result with nothing pending: sample_out %0d reduction_db %0d",
                 sample_out, reduction_db);
          err_cnt++;
        end else begin
          want = pending_out.pop_front();
          n_checked++;
          if (sample_out !== want.smp) begin
            $error("sample_out: expected %0d, got %0d", want.smp, sample_out);
            err_cnt++;
          end
          if (reduction_db !== want.db) begin
            $error("reduction_db: expected %0d, got %0d", want.db, reduction_db);
            err_cnt++;
          end
        end
      end
    end
    if (calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (run_left > 0) begin
        run_left <= run_left - 1;
      end else begin
        run_left <= $urandom_range(0, 60);
        stall_left <= $urandom_range(1, 19);
      end
    end
  end

  initial begin
    int drain_at;
    int lvl_left;
    int lvl_shift;
    bit gappy;
    result_t typed_res;
    env_fast = '0;
    env_slow = '0;
    gain_q16 = UNITY_GAIN;
    drive_amt = '0;
    pole_fast = FAST_COEFF_24;
    pole_slow = SLOW_COEFF_24;
    lvl_left = 0;
    lvl_shift = 0;
    gappy = 1'b0;
    // after reset amount is zero, so gain stays at unity and the first rows pass through
    dir_tab = '{
      '{ROW_SAMPLE, CFG_AMOUNT,     24'h7FFFFF, 1'b1, 24'h7FFFFF, 15'h0},
      '{ROW_SAMPLE, CFG_AMOUNT,     24'h800000, 1'b1, 24'h800000, 15'h0},
      '{ROW_SAMPLE, CFG_AMOUNT,     24'h000000, 1'b1, 24'h000000, 15'h0},
      '{ROW_SAMPLE, CFG_AMOUNT,     24'h000001, 1'b1, 24'h000001, 15'h0},
      '{ROW_SAMPLE, CFG_AMOUNT,     24'hFFFFFF, 1'b1, 24'hFFFFFF, 15'h0},
      '{ROW_REG,    CFG_AMOUNT,     24'hFFFFFF, 1'b0, 24'h0, 15'h0},
      '{ROW_SAMPLE, CFG_AMOUNT,     24'h7FFFFF, 1'b0, 24'h0, 15'h0},
      '{ROW_SAMPLE, CFG_AMOUNT,     24'h7FFFFF, 1'b0, 24'h0, 15'h0},
      '{ROW_SAMPLE, CFG_AMOUNT,     24'h800000, 1'b0, 24'h0, 15'h0},
      '{ROW_REG,    CFG_FAST_COEFF, 24'h000000, 1'b0, 24'h0, 15'h0},
      '{ROW_REG,    CFG_SLOW_COEFF, 24'h000000, 1'b0, 24'h0, 15'h0},
      '{ROW_SAMPLE, CFG_AMOUNT,     24'h7FFFFF, 1'b0, 24'h0, 15'h0},
      '{ROW_SAMPLE, CFG_AMOUNT,     24'h800000, 1'b0, 24'h0, 15'h0},
      '{ROW_SAMPLE, CFG_AMOUNT,     24'h000000, 1'b0, 24'h0, 15'h0},
      '{ROW_REG,    CFG_UNUSED,     24'h5A5A5A, 1'b0, 24'h0, 15'h0},
      '{ROW_REG,    CFG_FAST_COEFF, 24'hFFFFFF, 1'b0, 24'h0, 15'h0},
      '{ROW_REG,    CFG_SLOW_COEFF, 24'hFFFFFF, 1'b0, 24'h0, 15'h0},
      '{ROW_SAMPLE, CFG_AMOUNT,     24'h7FFFFF, 1'b0, 24'h0, 15'h0},
      '{ROW_SAMPLE, CFG_AMOUNT,     24'h000001, 1'b0, 24'h0, 15'h0},
      '{ROW_REG,    CFG_AMOUNT,     24'h020000, 1'b0, 24'h0, 15'h0},
      '{ROW_SAMPLE, CFG_AMOUNT,     24'h7FFFFF, 1'b0, 24'h0, 15'h0},
      '{ROW_REG,    CFG_AMOUNT,     24'h010000, 1'b0, 24'h0, 15'h0},
      '{ROW_REG,    CFG_FAST_COEFF, 24'(FAST_COEFF_24), 1'b0, 24'h0, 15'h0},
      '{ROW_REG,    CFG_SLOW_COEFF, 24'(SLOW_COEFF_24), 1'b0, 24'h0, 15'h0},
      '{ROW_SAMPLE, CFG_AMOUNT,     24'h400000, 1'b0, 24'h0, 15'h0},
      '{ROW_SAMPLE, CFG_AMOUNT,     24'hC00000, 1'b0, 24'h0, 15'h0}
    };
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_REG) begin
        drain_out();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        typed_res.smp = dir_tab[i].exp_smp;
        typed_res.db = dir_tab[i].exp_db;
        push_sample(dir_tab[i].data[SMP_W-1:0], dir_tab[i].typed, typed_res);
      end
    end

    for (int ph = 0; ph < N_PHASE; ph++) begin
      drain_out();
      calm = (ph == N_PHASE - 1);
      write_reg(CFG_AMOUNT, pick_amount());
      write_reg(CFG_FAST_COEFF, pick_pole());
      write_reg(CFG_SLOW_COEFF, pick_pole());
      if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, CFG_W'($urandom));
      drain_at = $urandom_range(10, PHASE_LEN - 10);
      for (int k = 0; k < PHASE_LEN; k++) begin
        // loud and quiet stretches so the envelopes swing both ways
        if (lvl_left == 0) begin
          lvl_left = $urandom_range(20, 120);
          lvl_shift = $urandom_range(0, 20);
          gappy = ($urandom_range(0, 2) != 0);
        end
        lvl_left--;
        if (k == drain_at)
          drain_out();
        else if (!calm && gappy && $urandom_range(0, 5) == 0)
          idle_in($urandom_range(1, 19));
        push_sample(pick_sample(lvl_shift), 1'b0, '0);
      end
    end

    lower_in();
    while (pending_out.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("tb_top: %0d results checked across %0d register writes and %0d phases",
             n_checked, n_writes, N_PHASE);
    $display("tb_top: %0d mismatches", err_cnt);
    if (err_cnt == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

[sim.f]
rtl/foc_pkg.sv
rtl/foc_mul.sv
rtl/foc_div.sv
rtl/feedback_opto_compressor.sv
sim/tb_top.sv
